// ----- rtl/gated_nearest_point_matcher_unit_assert.svh -----
// Assertion macros used by the checker file.
`ifndef GATED_NEAREST_POINT_MATCHER_UNIT_ASSERT_SVH
`define GATED_NEAREST_POINT_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GNPM_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define GNPM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/gnpm_pkg.sv -----
package gnpm_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned SqW     = 32;
  localparam int unsigned DistSqW = 33;
  localparam int unsigned RootW   = 17;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CoordW-1:0] MatchThrReset   = 16'd960;
  localparam logic [CoordW-1:0] InPlaceThrReset = 16'd64;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    STAT_ACCEPTED = 3'd0,
    STAT_MISSING  = 3'd1,
    STAT_IN_PLACE = 3'd2,
    STAT_MOVE     = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MATCH_THR    = 1'b0,
    CFG_IN_PLACE_THR = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_ROOT
  } state_e;

  typedef struct packed {
    logic shift;
    logic write;
    logic clear_used;
    logic set_used;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              used;
  } point_t;

endpackage

// ----- rtl/gnpm_cell.sv -----
module gnpm_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gnpm_pkg::cell_ctrl_t               ctrl_i,
  input  logic [gnpm_pkg::CoordW-1:0]        wr_x_i,
  input  logic [gnpm_pkg::CoordW-1:0]        wr_y_i,
  input  gnpm_pkg::point_t                   next_i,
  output gnpm_pkg::point_t                   point_o
);

  logic [gnpm_pkg::CoordW-1:0] x_q, x_d;
  logic [gnpm_pkg::CoordW-1:0] y_q, y_d;
  logic                        used_q, used_d;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    used_d = used_q;
    if (ctrl_i.clear_used) begin
      used_d = 1'b0;
    end else if (ctrl_i.write) begin
      x_d    = wr_x_i;
      y_d    = wr_y_i;
      used_d = 1'b0;
    end else if (ctrl_i.set_used) begin
      used_d = 1'b1;
    end else if (ctrl_i.shift) begin
      // take the neighbour's point, the ring rotates by one
      x_d    = next_i.x;
      y_d    = next_i.y;
      used_d = next_i.used;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign point_o.x    = x_q;
  assign point_o.y    = y_q;
  assign point_o.used = used_q;

endmodule

// ----- rtl/gnpm_sqrt.sv -----
module gnpm_sqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [gnpm_pkg::DistSqW-1:0]       value_i,
  output logic                               done_o,
  output logic [gnpm_pkg::CoordW-1:0]        root_o
);

  localparam int unsigned WorkW = gnpm_pkg::DistSqW + 1;
  localparam int unsigned StepW = $clog2(gnpm_pkg::RootW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [WorkW-1:0] rem_q, rem_d;
  logic [WorkW-1:0] res_q, res_d;
  logic [WorkW-1:0] pw;
  logic [WorkW-1:0] trial;

  assign pw    = WorkW'(1) << {step_q, 1'b0};
  assign trial = res_q + pw;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    res_d  = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(gnpm_pkg::RootW - 1);
      rem_d  = WorkW'(value_i);
      res_d  = '0;
    end else if (busy_q) begin
      // one result bit per cycle
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + pw;
      end else begin
        res_d = res_q >> 1;
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[gnpm_pkg::CoordW-1:0];

endmodule

// ----- rtl/gated_nearest_point_matcher_unit.sv -----
// Gated nearest point matcher.
// Command port: an item (mode_i, pos_x_i, pos_y_i) is taken on a clock edge
// with start_i high and busy_o low. Every item gives exactly one result,
// shown for one cycle with result_valid_o high; the receiver cannot stall.
// Clear, load and unused modes answer in the cycle after acceptance and keep
// busy_o low, so such items may follow every cycle.
// A query rotates the ring of point cells once past a shared distance
// pipeline and lets it drain, then takes the integer square root one bit
// a cycle. A matched query answers when the root is done; a missing one
// answers from the finish state without taking a root. busy_o stays high
// until the result shows.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (0 match threshold, 1 in-place threshold); write only while idle.
// Reset empties the store, clears every used mark and loads the default
// thresholds (60 px and 4 px in Q12.4).
module gated_nearest_point_matcher_unit #(
  parameter int unsigned MAX_POINTS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         mode_i,
  input  logic [gnpm_pkg::CoordW-1:0]        pos_x_i,
  input  logic [gnpm_pkg::CoordW-1:0]        pos_y_i,
  output logic                               result_valid_o,
  output logic [2:0]                         status_o,
  output logic [4:0]                         match_index_o,
  output logic [gnpm_pkg::CoordW-1:0]        match_distance_o,
  output logic [gnpm_pkg::CoordW-1:0]        match_x_o,
  output logic [gnpm_pkg::CoordW-1:0]        match_y_o,
  input  logic                               cfg_we_i,
  input  logic [gnpm_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [gnpm_pkg::CoordW-1:0]        cfg_wdata_i
);

  localparam int unsigned IdxW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned ScanW = $clog2(MAX_POINTS + 2);
  localparam int unsigned CW    = gnpm_pkg::CoordW;
  localparam int unsigned SqW   = gnpm_pkg::SqW;
  localparam int unsigned DW    = gnpm_pkg::DistSqW;
  localparam logic [ScanW-1:0] ScanLast = ScanW'(MAX_POINTS + 1);
  localparam logic [ScanW-1:0] ScanEnd  = ScanW'(MAX_POINTS);
  localparam logic [CntW-1:0]  CntFull  = CntW'(MAX_POINTS);

  gnpm_pkg::state_e  state_q, state_d;
  gnpm_pkg::mode_e   mode;

  logic [CW-1:0]     match_thr_q, in_place_thr_q;
  logic [CntW-1:0]   count_q;
  logic [ScanW-1:0]  scan_q;
  logic [CW-1:0]     qx_q, qy_q;

  logic [DW-1:0]     best_q;
  logic [IdxW-1:0]   best_idx_q;
  logic [CW-1:0]     best_x_q, best_y_q;
  logic              found_q;
  logic [SqW-1:0]    ip_sq_q;

  logic              s1_vld_q;
  logic [CW-1:0]     s1_dx_q, s1_dy_q, s1_x_q, s1_y_q;
  logic [IdxW-1:0]   s1_idx_q;
  logic              s2_vld_q;
  logic [SqW-1:0]    s2_sqx_q, s2_sqy_q;
  logic [CW-1:0]     s2_x_q, s2_y_q;
  logic [IdxW-1:0]   s2_idx_q;

  logic              res_vld_q;
  gnpm_pkg::status_e res_status_q;
  logic [4:0]        res_idx_q;
  logic [CW-1:0]     res_dist_q, res_x_q, res_y_q;

  logic              accept, load_ok;
  logic              do_clear, do_write, do_shift, do_feed, do_set_used, sqrt_start;
  logic              emit;
  gnpm_pkg::status_e emit_status;
  logic              emit_match;

  gnpm_pkg::point_t     cell_pt   [MAX_POINTS];
  gnpm_pkg::cell_ctrl_t cell_ctrl [MAX_POINTS];

  gnpm_pkg::point_t  head;
  logic              cand;
  logic [CW-1:0]     dx, dy;
  logic [DW-1:0]     d2;
  logic              upd;
  logic              sqrt_done;
  logic [CW-1:0]     sqrt_root;

  assign busy_o  = (state_q != gnpm_pkg::ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign mode    = gnpm_pkg::mode_e'(mode_i);
  assign load_ok = (count_q < CntFull);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gnpm_pkg::ST_IDLE: begin
        if (accept && mode == gnpm_pkg::MODE_QUERY) begin
          state_d = gnpm_pkg::ST_SCAN;
        end
      end
      gnpm_pkg::ST_SCAN: begin
        if (scan_q == ScanLast) begin
          state_d = gnpm_pkg::ST_FINISH;
        end
      end
      gnpm_pkg::ST_FINISH: begin
        state_d = found_q ? gnpm_pkg::ST_ROOT : gnpm_pkg::ST_IDLE;
      end
      gnpm_pkg::ST_ROOT: begin
        if (sqrt_done) begin
          state_d = gnpm_pkg::ST_IDLE;
        end
      end
      default: state_d = gnpm_pkg::ST_IDLE;
    endcase
  end

  // controls and results
  always_comb begin
    do_clear    = 1'b0;
    do_write    = 1'b0;
    do_shift    = 1'b0;
    do_feed     = 1'b0;
    do_set_used = 1'b0;
    sqrt_start  = 1'b0;
    emit        = 1'b0;
    emit_status = gnpm_pkg::STAT_ACCEPTED;
    emit_match  = 1'b0;
    unique case (state_q)
      gnpm_pkg::ST_IDLE: begin
        if (accept) begin
          case (mode)
            gnpm_pkg::MODE_CLEAR: begin
              do_clear = 1'b1;
              emit     = 1'b1;
            end
            gnpm_pkg::MODE_LOAD: begin
              do_write = load_ok;
              emit     = 1'b1;
              if (!load_ok) begin
                emit_status = gnpm_pkg::STAT_FULL;
              end
            end
            gnpm_pkg::MODE_QUERY: ;
            default: emit = 1'b1;
          endcase
        end
      end
      gnpm_pkg::ST_SCAN: begin
        do_shift = (scan_q < ScanEnd);
        do_feed  = (scan_q < ScanEnd);
      end
      gnpm_pkg::ST_FINISH: begin
        sqrt_start  = found_q;
        do_set_used = found_q;
        if (!found_q) begin
          emit        = 1'b1;
          emit_status = gnpm_pkg::STAT_MISSING;
        end
      end
      gnpm_pkg::ST_ROOT: begin
        if (sqrt_done) begin
          emit        = 1'b1;
          emit_match  = 1'b1;
          emit_status = (best_q < DW'(ip_sq_q)) ? gnpm_pkg::STAT_IN_PLACE
                                               : gnpm_pkg::STAT_MOVE;
        end
      end
      default: ;
    endcase
  end

  // ring of point cells, cell i takes from cell i+1
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    assign cell_ctrl[i].shift      = do_shift;
    assign cell_ctrl[i].clear_used = do_clear;
    assign cell_ctrl[i].write      = do_write && (count_q == CntW'(i));
    assign cell_ctrl[i].set_used   = do_set_used && (best_idx_q == IdxW'(i));

    gnpm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl[i]),
      .wr_x_i  (pos_x_i),
      .wr_y_i  (pos_y_i),
      .next_i  (cell_pt[(i + 1) % MAX_POINTS]),
      .point_o (cell_pt[i])
    );
  end

  // distance pipeline on the head of the ring
  assign head = cell_pt[0];
  assign cand = do_feed && !head.used && (scan_q < ScanW'(count_q));
  assign dx   = (head.x >= qx_q) ? (head.x - qx_q) : (qx_q - head.x);
  assign dy   = (head.y >= qy_q) ? (head.y - qy_q) : (qy_q - head.y);
  assign d2   = DW'(s2_sqx_q) + DW'(s2_sqy_q);
  assign upd  = s2_vld_q && (d2 < best_q);

  gnpm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (best_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= gnpm_pkg::ST_IDLE;
      match_thr_q    <= gnpm_pkg::MatchThrReset;
      in_place_thr_q <= gnpm_pkg::InPlaceThrReset;
      count_q        <= '0;
      scan_q         <= '0;
      found_q        <= 1'b0;
      s1_vld_q       <= 1'b0;
      s2_vld_q       <= 1'b0;
      res_vld_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      s1_vld_q  <= cand;
      s2_vld_q  <= s1_vld_q;
      res_vld_q <= emit;
      if (cfg_we_i) begin
        unique case (gnpm_pkg::cfg_idx_e'(cfg_index_i))
          gnpm_pkg::CFG_MATCH_THR:    match_thr_q    <= cfg_wdata_i;
          gnpm_pkg::CFG_IN_PLACE_THR: in_place_thr_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (do_clear) begin
        count_q <= '0;
      end else if (do_write) begin
        count_q <= count_q + CntW'(1);
      end
      if (accept && mode == gnpm_pkg::MODE_QUERY) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (state_q == gnpm_pkg::ST_SCAN) begin
          scan_q <= scan_q + ScanW'(1);
        end
        if (upd) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && mode == gnpm_pkg::MODE_QUERY) begin
      qx_q    <= pos_x_i;
      qy_q    <= pos_y_i;
      best_q  <= DW'(SqW'(match_thr_q) * SqW'(match_thr_q));
      ip_sq_q <= SqW'(in_place_thr_q) * SqW'(in_place_thr_q);
    end else if (upd) begin
      best_q     <= d2;
      best_idx_q <= s2_idx_q;
      best_x_q   <= s2_x_q;
      best_y_q   <= s2_y_q;
    end
    s1_dx_q  <= dx;
    s1_dy_q  <= dy;
    s1_x_q   <= head.x;
    s1_y_q   <= head.y;
    s1_idx_q <= scan_q[IdxW-1:0];
    s2_sqx_q <= SqW'(s1_dx_q) * SqW'(s1_dx_q);
    s2_sqy_q <= SqW'(s1_dy_q) * SqW'(s1_dy_q);
    s2_x_q   <= s1_x_q;
    s2_y_q   <= s1_y_q;
    s2_idx_q <= s1_idx_q;
    if (emit) begin
      res_status_q <= emit_status;
      res_idx_q    <= emit_match ? 5'(best_idx_q) : 5'd0;
      res_dist_q   <= emit_match ? sqrt_root : '0;
      res_x_q      <= emit_match ? best_x_q : '0;
      res_y_q      <= emit_match ? best_y_q : '0;
    end
  end

  assign result_valid_o   = res_vld_q;
  assign status_o         = res_status_q;
  assign match_index_o    = res_idx_q;
  assign match_distance_o = res_dist_q;
  assign match_x_o        = res_x_q;
  assign match_y_o        = res_y_q;

endmodule

// ----- rtl/gnpm_checker.sv -----
`include "gated_nearest_point_matcher_unit_assert.svh"

module gnpm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic [1:0]                         mode_i,
  input logic                               result_valid_o,
  input logic [2:0]                         status_o,
  input logic [4:0]                         match_index_o,
  input logic [gnpm_pkg::CoordW-1:0]        match_distance_o,
  input logic [gnpm_pkg::CoordW-1:0]        match_x_o,
  input logic [gnpm_pkg::CoordW-1:0]        match_y_o
);

  logic cmd_acc;
  logic no_match;
  logic fields_zero;

  assign cmd_acc     = start_i && !busy_o;
  assign no_match    = (status_o == gnpm_pkg::STAT_ACCEPTED) ||
                       (status_o == gnpm_pkg::STAT_MISSING) ||
                       (status_o == gnpm_pkg::STAT_FULL);
  assign fields_zero = (match_index_o == '0) && (match_distance_o == '0) &&
                       (match_x_o == '0) && (match_y_o == '0);

  // a query never answers in the next cycle and holds the port busy
  `GNPM_ASSERT_NEXT(a_query_busy, clk_i, rst_ni,
    cmd_acc && (mode_i == gnpm_pkg::MODE_QUERY), busy_o && !result_valid_o,
    "query item did not hold busy")

  // every other command answers at once
  `GNPM_ASSERT_NEXT(a_cmd_reply, clk_i, rst_ni,
    cmd_acc && (mode_i != gnpm_pkg::MODE_QUERY), result_valid_o,
    "command item gave no result in the next cycle")

  // a query releases busy together with its result
  `GNPM_ASSERT_SAME(a_done_reply, clk_i, rst_ni,
    $fell(busy_o), result_valid_o, "busy dropped without a result")

  // results without a match carry no point
  `GNPM_ASSERT_SAME(a_empty_fields, clk_i, rst_ni,
    result_valid_o && no_match, fields_zero, "unmatched result carries point data")

endmodule

bind gated_nearest_point_matcher_unit gnpm_checker u_gnpm_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned MaxPoints = 32;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned PrintCap = 150;
  localparam logic [1:0] ModeSpare = 2'd3;

  typedef struct packed {
    gnpm_pkg::status_e status;
    logic [4:0]        index;
    logic [15:0]       distance;
    logic [15:0]       x;
    logic [15:0]       y;
  } match_result_t;

  typedef struct packed {
    logic [1:0]    mode;
    logic [15:0]   x;
    logic [15:0]   y;
    logic          typed;
    match_result_t want;
  } stim_row_t;

  localparam match_result_t Accepted =
    '{gnpm_pkg::STAT_ACCEPTED, 5'd0, 16'd0, 16'd0, 16'd0};
  localparam match_result_t Missing  =
    '{gnpm_pkg::STAT_MISSING, 5'd0, 16'd0, 16'd0, 16'd0};

  localparam logic [15:0] MatchSet [6]   = '{16'd960, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd16};
  localparam logic [15:0] InPlaceSet [6] = '{16'd64, 16'd64, 16'd65535, 16'd0, 16'd0, 16'd1000};

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  mode_i;
  logic [15:0] pos_x_i;
  logic [15:0] pos_y_i;
  logic        result_valid_o;
  logic [2:0]  status_o;
  logic [4:0]  match_index_o;
  logic [15:0] match_distance_o;
  logic [15:0] match_x_o;
  logic [15:0] match_y_o;
  logic        cfg_we_i;
  logic [gnpm_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [15:0] cfg_wdata_i;

  // matcher state as the testbench sees it
  logic [15:0] pt_x [MaxPoints];
  logic [15:0] pt_y [MaxPoints];
  logic        pt_used [MaxPoints];
  int          stored_count = 0;
  logic [15:0] match_thr = gnpm_pkg::MatchThrReset;
  logic [15:0] in_place_thr = gnpm_pkg::InPlaceThrReset;

  match_result_t pending_matches[$];
  stim_row_t     directed_rows[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   sender_idle_pct = 0;

  gated_nearest_point_matcher_unit #(
    .MAX_POINTS(MaxPoints)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .mode_i          (mode_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .match_index_o   (match_index_o),
    .match_distance_o(match_distance_o),
    .match_x_o       (match_x_o),
    .match_y_o       (match_y_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [16:0] floor_root(longint unsigned v);
    logic [16:0] r;
    longint unsigned c;
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      c = longint'(r | (17'd1 << b));
      if (c * c <= v) r = c[16:0];
    end
    return r;
  endfunction

  // Greedy gated nearest match; updates the store as the block does.
  function automatic match_result_t predict_match(logic [1:0] mode, logic [15:0] x,
                                                  logic [15:0] y);
    match_result_t r;
    longint unsigned best, dx, dy, d2;
    int winner;
    r = Accepted;
    winner = -1;
    case (mode)
      gnpm_pkg::MODE_CLEAR: begin
        stored_count = 0;
        foreach (pt_used[i]) pt_used[i] = 1'b0;
      end
      gnpm_pkg::MODE_LOAD: begin
        if (stored_count >= MaxPoints) begin
          r.status = gnpm_pkg::STAT_FULL;
        end else begin
          pt_x[stored_count] = x;
          pt_y[stored_count] = y;
          pt_used[stored_count] = 1'b0;
          stored_count++;
        end
      end
      gnpm_pkg::MODE_QUERY: begin
        best = longint'(match_thr) * longint'(match_thr);
        for (int i = 0; i < stored_count; i++) begin
          if (!pt_used[i]) begin
            dx = (pt_x[i] >= x) ? longint'(pt_x[i] - x) : longint'(x - pt_x[i]);
            dy = (pt_y[i] >= y) ? longint'(pt_y[i] - y) : longint'(y - pt_y[i]);
            d2 = dx * dx + dy * dy;
            if (d2 < best) begin
              best = d2;
              winner = i;
            end
          end
        end
        if (winner < 0) begin
          r.status = gnpm_pkg::STAT_MISSING;
        end else begin
          pt_used[winner] = 1'b1;
          r.status = (best < longint'(in_place_thr) * longint'(in_place_thr)) ?
                     gnpm_pkg::STAT_IN_PLACE : gnpm_pkg::STAT_MOVE;
          r.index = winner[4:0];
          r.distance = 16'(floor_root(best));
          r.x = pt_x[winner];
          r.y = pt_y[winner];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_row(stim_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= PrintCap) $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    match_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_matches.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= PrintCap)
          $error("status: expected no result, actual %0d", status_o);
      end else begin
        want = pending_matches.pop_front();
        check_field("status", want.status, status_o);
        check_field("match_index", want.index, match_index_o);
        check_field("match_distance", want.distance, match_distance_o);
        check_field("match_x", want.x, match_x_o);
        check_field("match_y", want.y, match_y_o);
      end
    end
  end

  // Hold start high until the block takes the item, then log what it should answer.
  task automatic issue_item(logic [1:0] mode, logic [15:0] x, logic [15:0] y,
                            logic typed = 1'b0, match_result_t want = '0);
    match_result_t predicted;
    if ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    start_i <= 1'b1;
    mode_i  <= mode;
    pos_x_i <= x;
    pos_y_i <= y;
    do @(posedge clk_i); while (busy_o);
    predicted = predict_match(mode, x, y);
    if (typed) predicted = want;
    pending_matches = {pending_matches, predicted};
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_thresholds(logic [15:0] match_val, logic [15:0] in_place_val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= gnpm_pkg::CFG_MATCH_THR;
    cfg_wdata_i <= match_val;
    @(posedge clk_i);
    cfg_index_i <= gnpm_pkg::CFG_IN_PLACE_THR;
    cfg_wdata_i <= in_place_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    match_thr = match_val;
    in_place_thr = in_place_val;
  endtask

  function automatic logic [15:0] nudge(logic [15:0] c, int span);
    int v;
    v = int'(c) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic int pick_span();
    case ($urandom_range(3))
      0: return int'(match_thr) / 8;
      1: return int'(match_thr);
      2: return 2 * int'(match_thr) + 1;
      default: return 65535;
    endcase
  endfunction

  // Mostly clear/load/query sequences around a cluster, some plain noise.
  task automatic run_traffic(int items);
    int done, n, queries, k, span;
    logic [1:0] mode;
    logic [15:0] bx, by;
    done = 0;
    while (done < items) begin
      if ($urandom_range(99) < 8) begin
        mode = 2'($urandom_range(3));
        issue_item(mode, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
        if (mode != ModeSpare) done++;
      end else begin
        if ($urandom_range(3) != 0) begin
          issue_item(gnpm_pkg::MODE_CLEAR, 16'($urandom_range(16'hFFFF)),
                     16'($urandom_range(16'hFFFF)));
          done++;
        end
        n = ($urandom_range(7) == 0) ? $urandom_range(36, 28) : $urandom_range(10, 1);
        bx = 16'($urandom_range(16'hFFFF));
        by = 16'($urandom_range(16'hFFFF));
        span = pick_span();
        repeat (n) begin
          issue_item(gnpm_pkg::MODE_LOAD, nudge(bx, span), nudge(by, span));
          done++;
        end
        queries = $urandom_range(n + 2, 1);
        repeat (queries) begin
          if (stored_count == 0 || $urandom_range(5) == 0) begin
            issue_item(gnpm_pkg::MODE_QUERY, 16'($urandom_range(16'hFFFF)),
                       16'($urandom_range(16'hFFFF)));
          end else begin
            k = $urandom_range(stored_count - 1);
            issue_item(gnpm_pkg::MODE_QUERY, nudge(pt_x[k], pick_span()),
                       nudge(pt_y[k], pick_span()));
          end
          done++;
        end
      end
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    mode_i      <= gnpm_pkg::MODE_CLEAR;
    pos_x_i     <= '0;
    pos_y_i     <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= gnpm_pkg::CFG_MATCH_THR;
    cfg_wdata_i <= '0;
    foreach (pt_used[i]) begin
      pt_used[i] = 1'b0;
      pt_x[i] = '0;
      pt_y[i] = '0;
    end

    add_row('{gnpm_pkg::MODE_QUERY, 16'd0, 16'd0, 1'b1, Missing});
    add_row('{gnpm_pkg::MODE_LOAD, 16'd0, 16'd0, 1'b1, Accepted});
    add_row('{gnpm_pkg::MODE_LOAD, 16'd65535, 16'd65535, 1'b1, Accepted});
    add_row('{gnpm_pkg::MODE_QUERY, 16'd0, 16'd0, 1'b1,
              '{gnpm_pkg::STAT_IN_PLACE, 5'd0, 16'd0, 16'd0, 16'd0}});
    add_row('{gnpm_pkg::MODE_QUERY, 16'd0, 16'd0, 1'b1, Missing});
    add_row('{gnpm_pkg::MODE_QUERY, 16'd65535, 16'd65535, 1'b1,
              '{gnpm_pkg::STAT_IN_PLACE, 5'd1, 16'd0, 16'd65535, 16'd65535}});
    // every point now used
    add_row('{gnpm_pkg::MODE_QUERY, 16'd65535, 16'd65535, 1'b1, Missing});
    add_row('{ModeSpare, 16'd65535, 16'd65535, 1'b1, Accepted});
    add_row('{gnpm_pkg::MODE_LOAD, 16'd16000, 16'd16000, 1'b1, Accepted});
    // exactly on the in-place threshold: counts as a move
    add_row('{gnpm_pkg::MODE_QUERY, 16'd16064, 16'd16000, 1'b1,
              '{gnpm_pkg::STAT_MOVE, 5'd2, 16'd64, 16'd16000, 16'd16000}});
    add_row('{gnpm_pkg::MODE_LOAD, 16'd20000, 16'd20000, 1'b1, Accepted});
    add_row('{gnpm_pkg::MODE_LOAD, 16'd20000, 16'd20000, 1'b1, Accepted});
    // tie: the earlier point wins, the twin takes the next query
    add_row('{gnpm_pkg::MODE_QUERY, 16'd20010, 16'd20000, 1'b1,
              '{gnpm_pkg::STAT_IN_PLACE, 5'd3, 16'd10, 16'd20000, 16'd20000}});
    add_row('{gnpm_pkg::MODE_QUERY, 16'd20000, 16'd20063, 1'b1,
              '{gnpm_pkg::STAT_IN_PLACE, 5'd4, 16'd63, 16'd20000, 16'd20000}});
    add_row('{gnpm_pkg::MODE_LOAD, 16'd30000, 16'd30000, 1'b1, Accepted});
    // gate is strict
    add_row('{gnpm_pkg::MODE_QUERY, 16'd30960, 16'd30000, 1'b1, Missing});
    add_row('{gnpm_pkg::MODE_QUERY, 16'd30959, 16'd30000, 1'b1,
              '{gnpm_pkg::STAT_MOVE, 5'd5, 16'd959, 16'd30000, 16'd30000}});
    add_row('{gnpm_pkg::MODE_LOAD, 16'd40000, 16'd40000, 1'b1, Accepted});
    add_row('{gnpm_pkg::MODE_QUERY, 16'd40300, 16'd40400, 1'b1,
              '{gnpm_pkg::STAT_MOVE, 5'd6, 16'd500, 16'd40000, 16'd40000}});
    add_row('{gnpm_pkg::MODE_LOAD, 16'd50000, 16'd50000, 1'b1, Accepted});
    add_row('{gnpm_pkg::MODE_LOAD, 16'd50100, 16'd50000, 1'b1, Accepted});
    add_row('{gnpm_pkg::MODE_QUERY, 16'd50040, 16'd50000, 1'b1,
              '{gnpm_pkg::STAT_IN_PLACE, 5'd7, 16'd40, 16'd50000, 16'd50000}});
    add_row('{gnpm_pkg::MODE_QUERY, 16'd50001, 16'd50007, 1'b0, Accepted});
    add_row('{gnpm_pkg::MODE_CLEAR, 16'd65535, 16'd65535, 1'b1, Accepted});
    add_row('{gnpm_pkg::MODE_QUERY, 16'd50000, 16'd50000, 1'b1, Missing});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 23;
    foreach (directed_rows[i])
      issue_item(directed_rows[i].mode, directed_rows[i].x, directed_rows[i].y,
                 directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      if (p == 4) set_thresholds(16'($urandom_range(4095)), 16'($urandom_range(2047)));
      else set_thresholds(MatchSet[p], InPlaceSet[p]);
      sender_idle_pct = (p < 2) ? 23 : (p < 4) ? 69 : 0;
      run_traffic(200);
    end

    wait_idle();
    if (mismatch_count == 0 && pending_matches.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/gnpm_pkg.sv
rtl/gnpm_cell.sv
rtl/gnpm_sqrt.sv
rtl/gated_nearest_point_matcher_unit.sv
rtl/gnpm_checker.sv
verif/testbench.sv
